// ----- rtl/prtwa_pkg.sv -----
// Shared types and constants for the peer rate table with aging.
// Holds the controller state type and the command and status structs
// that join the controller to the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prtwa_pkg;

    localparam int KEY_W      = 32;
    localparam int RATE_W     = 24;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = 32;
    localparam int FIELD_IX_W = 6;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 48;

    localparam logic [TIME_W-1:0] STALE_RESET = 32'd11000;

    // Action codes carried in the input tuser bit.
    localparam logic ACT_REPORT = 1'b0;
    localparam logic ACT_STATS  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RATE_W-1:0] rate;
        logic [TIME_W-1:0] seen;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RPT_SCAN,
        ST_SHIFT,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic idx_zero;
        logic idx_pend1;
        logic step;
        logic hit_wr;
        logic app_wr;
        logic set_full;
        logic shift_wr;
        logic sum_acc;
        logic count_dec;
        logic pend_clr;
        logic mark_save;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_stats;
        logic scan_more;
        logic tag_v;
        logic key_hit;
        logic table_room;
        logic remove_ok;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/prtwa_ctrl.sv -----
// Controller for the peer rate table: sequences report scans, stale
// entry removal and the statistics pass. Depends on prtwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prtwa_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_valid,
    output logic              o_s_ready,
    input  prtwa_pkg::t_status i_status,
    output prtwa_pkg::t_cmd   o_cmd
);

    prtwa_pkg::t_state r_state;
    prtwa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prtwa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            prtwa_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = prtwa_pkg::ST_DISPATCH;
                end
            end
            prtwa_pkg::ST_DISPATCH: begin
                if (!i_status.is_stats) begin
                    o_cmd.idx_zero = 1'b1;
                    n_state        = prtwa_pkg::ST_RPT_SCAN;
                end else begin
                    o_cmd.pend_clr = 1'b1;
                    if (i_status.remove_ok) begin
                        o_cmd.idx_pend1 = 1'b1;
                        n_state         = prtwa_pkg::ST_SHIFT;
                    end else begin
                        o_cmd.idx_zero = 1'b1;
                        n_state        = prtwa_pkg::ST_SUM;
                    end
                end
            end
            prtwa_pkg::ST_RPT_SCAN: begin
                if (i_status.key_hit) begin
                    o_cmd.hit_wr = 1'b1;
                    n_state      = prtwa_pkg::ST_DONE;
                end else if (!i_status.tag_v && !i_status.scan_more) begin
                    if (i_status.table_room) begin
                        o_cmd.app_wr = 1'b1;
                    end else begin
                        o_cmd.set_full = 1'b1;
                    end
                    n_state = prtwa_pkg::ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            prtwa_pkg::ST_SHIFT: begin
                o_cmd.shift_wr = 1'b1;
                if (!i_status.tag_v && !i_status.scan_more) begin
                    o_cmd.count_dec = 1'b1;
                    o_cmd.idx_zero  = 1'b1;
                    n_state         = prtwa_pkg::ST_SUM;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            prtwa_pkg::ST_SUM: begin
                o_cmd.sum_acc = 1'b1;
                if (!i_status.tag_v && !i_status.scan_more) begin
                    o_cmd.mark_save = 1'b1;
                    n_state         = prtwa_pkg::ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            prtwa_pkg::ST_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = prtwa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prtwa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/prtwa_dpath.sv -----
// Datapath for the peer rate table: entry memory, count and removal mark,
// scan pointer, rate accumulator, age compare and result register.
// Depends on prtwa_pkg; driven by prtwa_ctrl through t_cmd.
`timescale 1ns / 1ps
`default_nettype none

module prtwa_dpath #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [prtwa_pkg::IN_DATA_W-1:0]     i_s_data,
    input  wire                                 i_s_action,
    input  wire                                 i_cfg_valid,
    input  wire  [prtwa_pkg::TIME_W-1:0]        i_cfg_data,
    input  wire                                 i_m_ready,
    output logic                                o_m_valid,
    output logic [prtwa_pkg::OUT_DATA_W-1:0]    o_m_data,
    input  prtwa_pkg::t_cmd                     i_cmd,
    output prtwa_pkg::t_status                  o_status
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    prtwa_pkg::t_entry r_mem [TABLE_ENTRIES];
    prtwa_pkg::t_entry r_rd;

    logic [prtwa_pkg::KEY_W-1:0]      r_key;
    logic [prtwa_pkg::RATE_W-1:0]     r_rate;
    logic [prtwa_pkg::TIME_W-1:0]     r_now;
    logic                             r_stats;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    r_pend;
    logic                             r_pend_v;
    logic [CW-1:0]                    r_idx;
    logic [CW-1:0]                    r_tag;
    logic                             r_tag_v;
    logic [prtwa_pkg::SUM_W-1:0]      r_sum;
    logic                             r_found;
    logic [CW-1:0]                    r_mark;
    logic [CW-1:0]                    r_res_idx;
    logic                             r_res_new;
    logic                             r_res_full;
    logic [prtwa_pkg::TIME_W-1:0]     r_stale_cfg;
    logic                             r_out_valid;
    logic [prtwa_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                             scan_more;
    logic                             we;
    logic [AW-1:0]                    wr_addr;
    prtwa_pkg::t_entry                wr_data;
    logic [CW-1:0]                    tag_m1;
    logic [CW-1:0]                    pend_p1;
    logic [prtwa_pkg::TIME_W-1:0]     age;
    logic                             is_stale;
    logic [prtwa_pkg::SUM_W:0]        sum_wide;
    logic [prtwa_pkg::SUM_W-1:0]      sum_sat;

    assign scan_more = (r_idx < r_count);
    assign tag_m1    = r_tag - CW'(1);
    assign pend_p1   = r_pend + CW'(1);

    // During compaction the entry read from slot n is written back to n-1.
    always_comb begin
        we      = i_cmd.hit_wr | i_cmd.app_wr | (i_cmd.shift_wr & r_tag_v);
        wr_data = '{key: r_key, rate: r_rate, seen: r_now};
        if (i_cmd.hit_wr) begin
            wr_addr = r_tag[AW-1:0];
        end else if (i_cmd.app_wr) begin
            wr_addr = r_count[AW-1:0];
        end else begin
            wr_addr = tag_m1[AW-1:0];
            wr_data = r_rd;
        end
    end

    assign age      = r_now - r_rd.seen;
    assign is_stale = (age >= r_stale_cfg);
    assign sum_wide = {1'b0, r_sum} + (prtwa_pkg::SUM_W + 1)'(r_rd.rate);
    assign sum_sat  = sum_wide[prtwa_pkg::SUM_W] ? '1 : sum_wide[prtwa_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.step && scan_more) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend_v    <= 1'b0;
            r_tag_v     <= 1'b0;
            r_out_valid <= 1'b0;
            r_stale_cfg <= prtwa_pkg::STALE_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_stale_cfg <= i_cfg_data;
            end
            if (i_cmd.app_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.pend_clr) begin
                r_pend_v <= 1'b0;
            end else if (i_cmd.mark_save && r_found) begin
                r_pend_v <= 1'b1;
            end
            if (i_cmd.accept || i_cmd.idx_zero || i_cmd.idx_pend1) begin
                r_tag_v <= 1'b0;
            end else if (i_cmd.step) begin
                r_tag_v <= scan_more;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key      <= i_s_data[prtwa_pkg::KEY_W-1:0];
            r_rate     <= i_s_data[prtwa_pkg::KEY_W +: prtwa_pkg::RATE_W];
            r_now      <= i_s_data[prtwa_pkg::KEY_W + prtwa_pkg::RATE_W +: prtwa_pkg::TIME_W];
            r_stats    <= i_s_action;
            r_sum      <= '0;
            r_found    <= 1'b0;
            r_mark     <= '0;
            r_res_idx  <= '0;
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
        end
        if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_pend1) begin
            r_idx <= pend_p1;
        end else if (i_cmd.step && scan_more) begin
            r_idx <= r_idx + CW'(1);
            r_tag <= r_idx;
        end
        if (i_cmd.mark_save && r_found) begin
            r_pend <= r_mark;
        end
        if (i_cmd.hit_wr) begin
            r_res_idx <= r_tag;
        end
        if (i_cmd.app_wr) begin
            r_res_idx <= r_count;
            r_res_new <= 1'b1;
        end
        if (i_cmd.set_full) begin
            r_res_full <= 1'b1;
        end
        if (i_cmd.sum_acc && r_tag_v) begin
            r_sum <= sum_sat;
            if (is_stale) begin
                r_found <= 1'b1;
                r_mark  <= r_tag;
            end
        end
        if (i_cmd.out_load) begin
            r_out_data <= {1'b0, r_found, r_sum, prtwa_pkg::FIELD_IX_W'(r_count),
                           r_res_full, r_res_new, prtwa_pkg::FIELD_IX_W'(r_res_idx)};
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;

    always_comb begin
        o_status.is_stats   = (r_stats == prtwa_pkg::ACT_STATS);
        o_status.scan_more  = scan_more;
        o_status.tag_v      = r_tag_v;
        o_status.key_hit    = r_tag_v && (r_rd.key == r_key);
        o_status.table_room = (r_count < CW'(TABLE_ENTRIES));
        o_status.remove_ok  = r_pend_v && (r_pend < r_count);
        o_status.out_busy   = r_out_valid && !i_m_ready;
    end

endmodule

`default_nettype wire

// ----- rtl/peer_rate_table_with_aging.sv -----
// Top level of the peer rate table with aging.
// Joins prtwa_ctrl and prtwa_dpath; uses prtwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// An input item enters on the s_axis channel; s_axis_tuser selects a peer
// report (0) or a statistics request (1). Each item gives exactly one result
// item on the m_axis channel. The stale threshold in ms is written through the
// i_cfg channel, which is always ready; write it only while the block is idle.
// A report scans the N stored entries one per cycle through the single read
// port of the entry memory. A key found at slot k ends the scan there; a new
// or dropped key is known only after all N entries are read. A statistics
// request first closes up the order after a marked entry at slot P and then
// sums rates and checks ages over all entries, one per cycle.
// One item is in work at a time; s_axis_tready is high only while idle.
// Results sit in an output register, so the next item is taken while the last
// result still waits. If m_axis_tready stays low, a finished second item holds
// until the register frees. Synchronous reset empties the table, clears the
// stale mark and loads the threshold with 11000; the memory needs no clearing,
// as only entries below the count are read.
module peer_rate_table_with_aging #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // peer_address [31:0], hash_rate [55:32], now_ms [87:56]
    input  wire  [87:0] s_axis_tdata,
    // action [0]
    input  wire  [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // entry_index [5:0], was_new [6], table_full [7], peer_count [13:8],
    // rate_total [45:14], stale_found [46], zero [47]
    output logic [47:0] m_axis_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_cfg_data
);

    prtwa_pkg::t_cmd    cmd;
    prtwa_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    prtwa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    prtwa_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_data    (s_axis_tdata),
        .i_s_action  (s_axis_tuser[0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

`ifndef SYNTHESIS
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.app_wr |-> status.table_room)
        else $error("append issued with the table full");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !status.out_busy)
        else $error("result loaded over an unsent result");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new item taken while one is in work");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.hit_wr |-> status.tag_v)
        else $error("key hit without valid read data");
`endif

endmodule

`default_nettype wire
